[hw/rtl/lzwd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared codes and types of the LZW code stream decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

  // Reserved LZW codes
  localparam int unsigned CLEAR_CODE = 256;
  localparam int unsigned END_CODE   = 257;
  localparam int unsigned FIRST_FREE = 258;
  localparam int unsigned MIN_WIDTH  = 9;

  // Item kinds
  localparam logic [1:0] KIND_FEED = 2'd0;
  localparam logic [1:0] KIND_PULL = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;
  localparam logic [1:0] KIND_NOP  = 2'd3;

  // Result status codes
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_NEED_INPUT  = 4'd1;
  localparam logic [3:0] ST_EARLY_END   = 4'd2;
  localparam logic [3:0] ST_BAD_CLEAR   = 4'd3;
  localparam logic [3:0] ST_NO_CLEAR    = 4'd4;
  localparam logic [3:0] ST_BAD_CODE    = 4'd5;
  localparam logic [3:0] ST_INPUT_FULL  = 4'd6;
  localparam logic [3:0] ST_DATA_LEFT   = 4'd7;
  localparam logic [3:0] ST_EXTRA_BYTES = 4'd8;
  localparam logic [3:0] ST_NO_END      = 4'd9;
  localparam logic [3:0] ST_CLEAN_END   = 4'd10;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_CODE,
    S_CNT,
    S_WR,
    S_FETCH,
    S_RD,
    S_DONE
  } state_e;

endpackage
`default_nettype wire

[hw/rtl/lzwd_intf.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lzwd_in_if / lzwd_out_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface lzwd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] code_byte;
  logic       first_of_strip;

  modport source (output valid, output kind, output code_byte, output first_of_strip,
                  input ready);
  modport sink   (input valid, input kind, input code_byte, input first_of_strip,
                  output ready);
endinterface

interface lzwd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic [3:0] status;

  modport source (output valid, output out_byte, output out_valid, output status,
                  input ready);
  modport sink   (input valid, input out_byte, input out_valid, input status,
                  output ready);
endinterface
`default_nettype wire

[hw/rtl/lzwd_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lzwd_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lzwd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

[hw/rtl/lzw_code_stream_decoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lzw_code_stream_decoder
// TIFF LZW strip decoder: byte feed, byte pull and end-of-strip check.
// ----------------------------------------------------------------------------
// One request word in, one result word out. Feed, end-check and no-op words
// go from accept through the dispatch state to the result; a pull served from
// an already expanded string goes through dispatch, fetch and read. A pull
// that needs a new code walks the prefix chain through the dictionary RAM
// twice (length count, then expand into the string RAM), one entry per cycle
// each pass, then fetches and reads its byte. Each clear code taken on the
// way is consumed in its own pass through the code state.
// The dictionary and string RAMs are not cleared; no clearing pass is run.
// A new word is taken once the previous result has moved to the output
// register.
// ----------------------------------------------------------------------------
module lzw_code_stream_decoder #(
  parameter int unsigned MAX_CODE_BITS = 12,
  parameter int unsigned STORE_DEPTH   = 4096
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   cfg_we_i,
  input  wire logic   cfg_wdata_i,
  lzwd_in_if.sink     word_i,
  lzwd_out_if.source  res_o
);
  import lzwd_pkg::*;

  localparam int unsigned CW       = MAX_CODE_BITS;
  localparam int unsigned NCW      = CW + 1;
  localparam int unsigned DictD    = (1 << CW) - FIRST_FREE;
  localparam int unsigned DAW      = $clog2(DictD);
  localparam int unsigned SAW      = $clog2(STORE_DEPTH);
  localparam int unsigned SLW      = $clog2(STORE_DEPTH + 1);
  localparam int unsigned DW       = CW + 8;

  // ---------------- registers ----------------
  state_e           state_q, state_d;
  logic [1:0]       kind_q, kind_d;
  logic [7:0]       byte_q, byte_d;
  logic             rev_q;
  logic [31:0]      buf_q, buf_d;
  logic [5:0]       cnt_q, cnt_d;
  logic [4:0]       wid_q, wid_d;
  logic [NCW-1:0]   next_q, next_d;
  logic [CW-1:0]    prev_q, prev_d;
  logic [7:0]       fchar_q, fchar_d;
  logic [SAW-1:0]   base_q, base_d;
  logic [SLW-1:0]   rem_q, rem_d;
  logic [SLW-1:0]   len_q, len_d;
  logic [CW-1:0]    nc_q, nc_d;
  logic [CW-1:0]    walk_q, walk_d;
  logic             first_q, first_d;
  logic [SLW-1:0]   steps_q, steps_d;
  logic [SLW-1:0]   pos_q, pos_d;
  logic [7:0]       rbyte_q, rbyte_d;
  logic             rvld_q, rvld_d;
  logic [3:0]       rst_q, rst_d;
  logic             ovld_q, ovld_d;
  logic [7:0]       obyte_q;
  logic             oflag_q;
  logic [3:0]       ostat_q;

  // ---------------- memories ----------------
  logic           d_we;
  logic [DAW-1:0] d_waddr, d_raddr;
  logic [DW-1:0]  d_wdata, d_rdata;
  logic           s_we;
  logic [SAW-1:0] s_waddr, s_raddr;
  logic [7:0]     s_wdata, s_rdata;

  lzwd_ram #(.Width(DW), .Depth(DictD)) u_dict (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  lzwd_ram #(.Width(8), .Depth(STORE_DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  // ---------------- handshake ----------------
  logic in_acc, out_free, load_out;
  assign in_acc   = word_i.valid && (state_q == S_IDLE);
  assign out_free = !ovld_q || res_o.ready;
  assign load_out = (state_q == S_DONE) && out_free;
  assign word_i.ready = (state_q == S_IDLE);

  assign res_o.valid     = ovld_q;
  assign res_o.out_byte  = obyte_q;
  assign res_o.out_valid = oflag_q;
  assign res_o.status    = ostat_q;

  // ---------------- shared helpers ----------------
  logic [NCW-1:0] wmask;     // (1 << width) - 1
  logic [NCW-1:0] next_inc;
  logic [4:0]     wid_grow;
  logic [5:0]     code_sh;
  logic [31:0]    code_word;
  logic [CW-1:0]  nc_now;
  logic [7:0]     fed_byte;
  logic [CW-1:0]  cur_c;
  logic [CW-1:0]  pre_c;
  logic [SLW:0]   idx_sum;
  logic [SAW-1:0] idx;

  assign wmask    = (NCW'(1) << wid_q) - NCW'(1);
  assign next_inc = next_q + NCW'(1);
  assign wid_grow = ((next_inc == wmask) && (wid_q < 5'(CW))) ? wid_q + 5'd1 : wid_q;
  assign code_sh  = cnt_q - 6'(wid_q);
  assign code_word = buf_q >> code_sh;
  assign nc_now   = code_word[CW-1:0] & wmask[CW-1:0];
  assign pre_c    = d_rdata[DW-1:8];
  assign cur_c    = first_q ? walk_q : pre_c;
  assign idx_sum  = (SLW+1)'(base_q) + (SLW+1)'(rem_q) - (SLW+1)'(1);
  assign idx      = (idx_sum >= (SLW+1)'(STORE_DEPTH)) ?
                    SAW'(idx_sum - (SLW+1)'(STORE_DEPTH)) : SAW'(idx_sum);

  // fill order 2 reversal
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      fed_byte[i] = rev_q ? byte_q[7-i] : byte_q[i];
    end
  end

  // end-of-strip check
  logic signed [7:0] ec_r, ec_r1;
  logic [31:0]       ec_mask, ec_w0, ec_w1;
  logic [3:0]        ec_stat;
  always_comb begin
    ec_r    = $signed({2'b00, cnt_q}) - $signed({3'b000, wid_q});
    ec_r1   = ec_r + 8'sd1;
    ec_mask = 32'((33'(1) << wid_q) - 33'(1));
    ec_w0   = (buf_q >> ec_r[5:0]) & ec_mask;
    ec_w1   = (buf_q >> ec_r1[5:0]) & (ec_mask >> 1);
    if (rem_q != '0) begin
      ec_stat = ST_DATA_LEFT;
    end else if (ec_r >= 8'sd8) begin
      ec_stat = ST_EXTRA_BYTES;
    end else if (ec_r >= 8'sd0 && ec_w0 == 32'(END_CODE)) begin
      ec_stat = ST_CLEAN_END;
    end else if (ec_r >= -8'sd1 && ec_w1 == 32'(END_CODE)) begin
      ec_stat = ST_CLEAN_END;
    end else begin
      ec_stat = ST_NO_END;
    end
  end

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_DISP;
      S_DISP: begin
        if (kind_q == KIND_PULL) begin
          state_d = (rem_q != '0) ? S_FETCH : S_CODE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_CODE: begin
        if (cnt_q < 6'(wid_q)) begin
          state_d = S_DONE;
        end else if (nc_now == CW'(END_CODE)) begin
          state_d = S_DONE;
        end else if (nc_now == CW'(CLEAR_CODE)) begin
          state_d = S_CODE;
        end else if (prev_q == CW'(CLEAR_CODE)) begin
          state_d = (nc_now >= CW'(CLEAR_CODE)) ? S_DONE : S_FETCH;
        end else if (next_q >= NCW'(1 << CW)) begin
          state_d = S_DONE;
        end else if ({1'b0, nc_now} > next_q) begin
          state_d = S_DONE;
        end else if ({1'b0, nc_now} < next_q) begin
          state_d = S_CNT;
        end else begin
          state_d = (len_q == SLW'(STORE_DEPTH)) ? S_DONE : S_FETCH;
        end
      end
      S_CNT: begin
        if (cur_c >= CW'(FIRST_FREE)) begin
          if (steps_q + SLW'(1) >= SLW'(STORE_DEPTH)) state_d = S_DONE;
        end else begin
          state_d = S_WR;
        end
      end
      S_WR:    if (first_q && walk_q < CW'(FIRST_FREE)) state_d = S_FETCH;
      S_FETCH: state_d = S_RD;
      S_RD:    state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------- datapath and memory control ----------------
  always_comb begin
    kind_d  = kind_q;   byte_d  = byte_q;
    buf_d   = buf_q;    cnt_d   = cnt_q;   wid_d  = wid_q;
    next_d  = next_q;   prev_d  = prev_q;  fchar_d = fchar_q;
    base_d  = base_q;   rem_d   = rem_q;   len_d  = len_q;
    nc_d    = nc_q;     walk_d  = walk_q;  first_d = first_q;
    steps_d = steps_q;  pos_d   = pos_q;
    rbyte_d = rbyte_q;  rvld_d  = rvld_q;  rst_d  = rst_q;
    d_we    = 1'b0;
    d_waddr = DAW'(next_q - NCW'(FIRST_FREE));
    d_wdata = {prev_q, fchar_q};
    d_raddr = DAW'(cur_c - CW'(FIRST_FREE));
    s_we    = 1'b0;
    s_waddr = '0;
    s_wdata = '0;
    s_raddr = idx;

    case (state_q)
      // take word, strip start resets decoder state
      S_IDLE: begin
        if (in_acc) begin
          kind_d = word_i.kind;
          byte_d = word_i.code_byte;
          if (word_i.first_of_strip) begin
            buf_d = '0; cnt_d = '0; wid_d = 5'(MIN_WIDTH);
            next_d = NCW'(FIRST_FREE); prev_d = CW'(CLEAR_CODE);
            fchar_d = '0; base_d = '0; rem_d = '0; len_d = '0;
          end
        end
      end
      S_DISP: begin
        rbyte_d = '0;
        rvld_d  = 1'b0;
        rst_d   = ST_OK;
        case (kind_q)
          KIND_FEED: begin
            if (cnt_q > 6'd24) begin
              rst_d = ST_INPUT_FULL;
            end else begin
              buf_d = {buf_q[23:0], fed_byte};
              cnt_d = cnt_q + 6'd8;
            end
          end
          KIND_END: rst_d = ec_stat;
          default: ;
        endcase
      end
      // consume one code
      S_CODE: begin
        if (cnt_q < 6'(wid_q)) begin
          rst_d = ST_NEED_INPUT;
        end else begin
          cnt_d = code_sh;
          nc_d  = nc_now;
          if (nc_now == CW'(END_CODE)) begin
            rst_d = ST_EARLY_END;
          end else if (nc_now == CW'(CLEAR_CODE)) begin
            wid_d  = 5'(MIN_WIDTH);
            prev_d = CW'(CLEAR_CODE);
          end else if (prev_q == CW'(CLEAR_CODE)) begin
            if (nc_now >= CW'(CLEAR_CODE)) begin
              rst_d = ST_BAD_CLEAR;
            end else begin
              s_we    = 1'b1;
              s_waddr = '0;
              s_wdata = nc_now[7:0];
              base_d  = '0;
              fchar_d = nc_now[7:0];
              len_d   = SLW'(1);
              rem_d   = SLW'(1);
              next_d  = NCW'(FIRST_FREE);
              prev_d  = nc_now;
            end
          end else if (next_q >= NCW'(1 << CW)) begin
            rst_d = ST_NO_CLEAR;
          end else if ({1'b0, nc_now} > next_q) begin
            rst_d = ST_BAD_CODE;
          end else if ({1'b0, nc_now} < next_q) begin
            walk_d  = nc_now;
            first_d = 1'b1;
            steps_d = '0;
          end else if (len_q == SLW'(STORE_DEPTH)) begin
            rst_d = ST_BAD_CODE;
          end else begin
            // code equals next free code: prepend first char
            base_d  = (base_q == '0) ? SAW'(STORE_DEPTH - 1) : base_q - SAW'(1);
            s_we    = 1'b1;
            s_waddr = (base_q == '0) ? SAW'(STORE_DEPTH - 1) : base_q - SAW'(1);
            s_wdata = fchar_q;
            len_d   = len_q + SLW'(1);
            rem_d   = len_q + SLW'(1);
            d_we    = 1'b1;
            next_d  = next_inc;
            wid_d   = wid_grow;
            prev_d  = nc_now;
          end
        end
      end
      // chain length pass
      S_CNT: begin
        if (cur_c >= CW'(FIRST_FREE)) begin
          if (steps_q + SLW'(1) >= SLW'(STORE_DEPTH)) begin
            rst_d = ST_BAD_CODE;
          end else begin
            steps_d = steps_q + SLW'(1);
            first_d = 1'b0;
          end
        end else begin
          walk_d  = nc_q;
          first_d = 1'b1;
          pos_d   = '0;
        end
      end
      // expansion pass, last byte of the string first
      S_WR: begin
        if (first_q) begin
          if (walk_q >= CW'(FIRST_FREE)) begin
            d_raddr = DAW'(walk_q - CW'(FIRST_FREE));
            first_d = 1'b0;
          end else begin
            s_we    = 1'b1;
            s_waddr = SAW'(pos_q);
            s_wdata = walk_q[7:0];
            fchar_d = walk_q[7:0];
            base_d  = '0;
            len_d   = pos_q + SLW'(1);
            rem_d   = pos_q + SLW'(1);
            d_we    = 1'b1;
            d_wdata = {prev_q, walk_q[7:0]};
            next_d  = next_inc;
            wid_d   = wid_grow;
            prev_d  = nc_q;
          end
        end else begin
          s_we    = 1'b1;
          s_waddr = SAW'(pos_q);
          s_wdata = d_rdata[7:0];
          pos_d   = pos_q + SLW'(1);
          d_raddr = DAW'(pre_c - CW'(FIRST_FREE));
          if (pre_c < CW'(FIRST_FREE)) begin
            walk_d  = pre_c;
            first_d = 1'b1;
          end
        end
      end
      S_FETCH: rem_d = rem_q - SLW'(1);
      S_RD: begin
        rbyte_d = s_rdata;
        rvld_d  = 1'b1;
        rst_d   = ST_OK;
      end
      default: ;
    endcase
  end

  // output register
  always_comb begin
    ovld_d = ovld_q;
    if (load_out) begin
      ovld_d = 1'b1;
    end else if (res_o.ready) begin
      ovld_d = 1'b0;
    end
  end

  // ---------------- state registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rev_q   <= 1'b0;
      buf_q   <= '0;
      cnt_q   <= '0;
      wid_q   <= 5'(MIN_WIDTH);
      next_q  <= NCW'(FIRST_FREE);
      prev_q  <= CW'(CLEAR_CODE);
      fchar_q <= '0;
      base_q  <= '0;
      rem_q   <= '0;
      len_q   <= '0;
      first_q <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) rev_q <= cfg_wdata_i;
      buf_q   <= buf_d;
      cnt_q   <= cnt_d;
      wid_q   <= wid_d;
      next_q  <= next_d;
      prev_q  <= prev_d;
      fchar_q <= fchar_d;
      base_q  <= base_d;
      rem_q   <= rem_d;
      len_q   <= len_d;
      first_q <= first_d;
      ovld_q  <= ovld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    byte_q  <= byte_d;
    nc_q    <= nc_d;
    walk_q  <= walk_d;
    steps_q <= steps_d;
    pos_q   <= pos_d;
    rbyte_q <= rbyte_d;
    rvld_q  <= rvld_d;
    rst_q   <= rst_d;
    if (load_out) begin
      obyte_q <= rbyte_q;
      oflag_q <= rvld_q;
      ostat_q <= rst_q;
    end
  end

endmodule
`default_nettype wire

[verif/lzw_code_stream_decoder_test.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lzw_code_stream_decoder_test
// Self-checking bench for the TIFF LZW strip decoder.
// ----------------------------------------------------------------------------
// Code streams are built here with a mirror of the decoder's width rules and
// packed MSB first. They are fed as feed words, with pull and end-check
// words mixed in, under several idle/stall mixes and both fill orders. A
// software copy of the decoder predicts every result word. A scoreboard
// compares each result word field by field against the oldest prediction.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [7:0] data;
  logic       data_ok;
  logic [3:0] status;
} lzw_result_t;

class lzw_scoreboard;
  // decoder mirror
  bit              rev;
  bit [31:0]       bits;
  int unsigned     nbits, width, next_free, prev, first_ch, base, remain, slen;
  bit [11:0]       prefix_mem[3838];
  bit [7:0]        suffix_mem[3838];
  bit [7:0]        store_mem[4096];
  lzw_result_t     pending_q[$];
  int              errors, words_in, results, status_seen[16];
  logic [3:0]      last_status;

  function new();
    rev = 0;
    restart();
  endfunction

  function void restart();
    bits = 0; nbits = 0; width = lzwd_pkg::MIN_WIDTH; next_free = lzwd_pkg::FIRST_FREE;
    prev = lzwd_pkg::CLEAR_CODE; first_ch = 0; base = 0; remain = 0; slen = 0;
  endfunction

  function logic [3:0] take_code(int unsigned c);
    int unsigned c2, steps, pos;
    if (c == lzwd_pkg::END_CODE) return lzwd_pkg::ST_EARLY_END;
    if (c == lzwd_pkg::CLEAR_CODE) begin
      width = lzwd_pkg::MIN_WIDTH;
    end else if (prev == lzwd_pkg::CLEAR_CODE) begin
      if (c >= 256) return lzwd_pkg::ST_BAD_CLEAR;
      base = 0; store_mem[0] = c[7:0]; first_ch = c;
      slen = 1; remain = 1; next_free = lzwd_pkg::FIRST_FREE;
    end else begin
      if (next_free >= 4096) return lzwd_pkg::ST_NO_CLEAR;
      if (c > next_free) return lzwd_pkg::ST_BAD_CODE;
      if (c < next_free) begin
        c2 = c; steps = 0; pos = 0;
        while (c2 >= lzwd_pkg::FIRST_FREE) begin
          if (steps + 1 >= 4096 || c2 - lzwd_pkg::FIRST_FREE >= 3838)
            return lzwd_pkg::ST_BAD_CODE;
          c2 = prefix_mem[c2 - lzwd_pkg::FIRST_FREE];
          steps++;
        end
        // expand from the tail of the string toward its head
        c2 = c;
        while (c2 >= lzwd_pkg::FIRST_FREE && pos < steps) begin
          store_mem[pos] = suffix_mem[c2 - lzwd_pkg::FIRST_FREE];
          pos++;
          c2 = prefix_mem[c2 - lzwd_pkg::FIRST_FREE];
        end
        store_mem[pos] = c2[7:0];
        pos++;
        first_ch = c2 & 8'hFF; base = 0; slen = pos;
      end else begin
        // code equals next free: previous string plus its own first byte
        if (slen + 1 > 4096) return lzwd_pkg::ST_BAD_CODE;
        base = (base == 0) ? 4095 : base - 1;
        store_mem[base] = first_ch[7:0];
        slen++;
      end
      remain = slen;
      prefix_mem[next_free - lzwd_pkg::FIRST_FREE] = prev[11:0];
      suffix_mem[next_free - lzwd_pkg::FIRST_FREE] = first_ch[7:0];
      next_free++;
      if (next_free == (1 << width) - 1 && width < 12) width++;
    end
    prev = c;
    return lzwd_pkg::ST_OK;
  endfunction

  function logic [3:0] end_check();
    int          r;
    int unsigned m;
    if (remain > 0) return lzwd_pkg::ST_DATA_LEFT;
    r = int'(nbits) - int'(width);
    if (r >= 8) return lzwd_pkg::ST_EXTRA_BYTES;
    m = (1 << width) - 1;
    if (r >= 0 && ((bits >> r) & m) == lzwd_pkg::END_CODE) return lzwd_pkg::ST_CLEAN_END;
    if (r >= -1 && ((bits >> (r + 1)) & (m >> 1)) == lzwd_pkg::END_CODE)
      return lzwd_pkg::ST_CLEAN_END;
    return lzwd_pkg::ST_NO_END;
  endfunction

  // Accepted request word: predict its result word
  function void note_word(logic [1:0] kind, logic [7:0] cb, logic first);
    lzw_result_t res;
    int unsigned idx, c;
    bit [7:0]    fb;
    res = '0;
    words_in++;
    if (first) restart();
    if (kind == lzwd_pkg::KIND_FEED) begin
      if (nbits + 8 > 32) begin
        res.status = lzwd_pkg::ST_INPUT_FULL;
      end else begin
        for (int i = 0; i < 8; i++) fb[7 - i] = cb[i];
        bits = (bits << 8) | (rev ? fb : cb);
        nbits += 8;
      end
    end else if (kind == lzwd_pkg::KIND_PULL) begin
      while (remain == 0 && res.status == lzwd_pkg::ST_OK) begin
        if (nbits < width) begin
          res.status = lzwd_pkg::ST_NEED_INPUT;
          break;
        end
        nbits -= width;
        c = (bits >> nbits) & ((1 << width) - 1);
        res.status = take_code(c);
      end
      if (res.status == lzwd_pkg::ST_OK) begin
        idx = base + remain - 1;
        if (idx >= 4096) idx -= 4096;
        res.data = store_mem[idx];
        res.data_ok = 1'b1;
        remain--;
      end
    end else if (kind == lzwd_pkg::KIND_END) begin
      res.status = end_check();
    end
    last_status = res.status;
    status_seen[res.status]++;
    pending_q.push_back(res);
  endfunction

  // Accepted result word: compare with the oldest prediction
  function void check_result(logic [7:0] data, logic data_ok, logic [3:0] status);
    lzw_result_t want;
    results++;
    if (pending_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result word byte=%h valid=%b status=%0d",
               $time, data, data_ok, status);
      return;
    end
    want = pending_q.pop_front();
    if (data_ok !== want.data_ok) begin
      errors++;
      $display("%0t: out_valid expected %b actual %b", $time, want.data_ok, data_ok);
    end
    if (data !== want.data) begin
      errors++;
      $display("%0t: out_byte expected %h actual %h", $time, want.data, data);
    end
    if (status !== want.status) begin
      errors++;
      $display("%0t: status expected %0d actual %0d", $time, want.status, status);
    end
  endfunction
endclass

module lzw_code_stream_decoder_test;
  import lzwd_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;

  logic clk_i, rst_ni, cfg_we_i, cfg_wdata_i;
  lzwd_in_if  word_if ();
  lzwd_out_if res_if ();

  lzw_code_stream_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .word_i      (word_if),
    .res_o       (res_if)
  );

  lzw_scoreboard sb;
  int            send_idle, recv_stall, hold_left, strips;
  bit            hold_req;
  logic [7:0]    strip_bytes[$];
  int            code_list[$];

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Timeout
  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    res_if.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = 400;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready = 1'b0;
      end else begin
        res_if.ready = ($urandom_range(99) >= recv_stall);
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      sb.check_result(res_if.out_byte, res_if.out_valid, res_if.status);
  end

  // Send one request word and log it once accepted
  task automatic send_word(logic [1:0] kind, logic [7:0] cb, logic first);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      word_if.valid = 1'b0;
      word_if.kind = $urandom_range(3);
      word_if.code_byte = $urandom_range(255);
      word_if.first_of_strip = $urandom_range(1);
      @(negedge clk_i);
    end
    word_if.valid = 1'b1;
    word_if.kind = kind;
    word_if.code_byte = cb;
    word_if.first_of_strip = first;
    do @(posedge clk_i); while (!word_if.ready);
    sb.note_word(kind, cb, first);
  endtask

  // Pack code_list into strip_bytes, MSB first, width tracked as the decoder does
  task automatic pack_codes();
    bit [63:0]   acc;
    int          nacc, w, nxt;
    bit          after_clear;
    bit [7:0]    b, fb;
    acc = 0; nacc = 0; w = MIN_WIDTH; nxt = FIRST_FREE; after_clear = 1;
    strip_bytes.delete();
    foreach (code_list[i]) begin
      acc = (acc << w) | code_list[i];
      nacc += w;
      while (nacc >= 8) begin
        b = acc >> (nacc - 8);
        for (int k = 0; k < 8; k++) fb[7 - k] = b[k];
        strip_bytes.push_back(sb.rev ? fb : b);
        nacc -= 8;
      end
      if (code_list[i] == CLEAR_CODE) begin
        w = MIN_WIDTH; after_clear = 1;
      end else if (code_list[i] < CLEAR_CODE && after_clear) begin
        after_clear = 0; nxt = FIRST_FREE;
      end else if (!after_clear && code_list[i] <= nxt && code_list[i] != END_CODE) begin
        nxt++;
        if (nxt == (1 << w) - 1 && w < 12) w++;
      end
    end
    if (nacc > 0) begin
      b = acc << (8 - nacc);
      for (int k = 0; k < 8; k++) fb[7 - k] = b[k];
      strip_bytes.push_back(sb.rev ? fb : b);
    end
  endtask

  // Well-formed code list with random content
  task automatic make_codes(int n, int lit_pct, int clr_pct);
    int  nxt;
    bit  after_clear;
    code_list.delete();
    after_clear = 1; nxt = FIRST_FREE;
    if ($urandom_range(1)) code_list.push_back(CLEAR_CODE);
    for (int i = 0; i < n; i++) begin
      if (after_clear) begin
        code_list.push_back($urandom_range(255));
        after_clear = 0; nxt = FIRST_FREE;
      end else if ($urandom_range(99) < clr_pct) begin
        code_list.push_back(CLEAR_CODE);
        after_clear = 1;
      end else if ($urandom_range(99) < lit_pct) begin
        code_list.push_back($urandom_range(255));
        nxt++;
      end else begin
        code_list.push_back($urandom_range(FIRST_FREE, nxt));
        nxt++;
      end
    end
    code_list.push_back(END_CODE);
  endtask

  // Drive strip_bytes as one strip, mixing pulls and end checks
  task automatic drive_strip();
    int idx, r, guard;
    idx = 0; guard = 0;
    strips++;
    while (guard < 3000) begin
      guard++;
      r = $urandom_range(99);
      if (r < 3) begin
        send_word(KIND_END, $urandom_range(255), idx == 0);
      end else if (idx >= strip_bytes.size() && sb.remain == 0 && r < 20) begin
        send_word(KIND_END, $urandom_range(255), 1'b0);
        break;
      end else if (idx < strip_bytes.size() && sb.nbits <= 24 && (sb.remain == 0 || r < 40)) begin
        send_word(KIND_FEED, strip_bytes[idx], idx == 0);
        idx++;
      end else begin
        send_word(KIND_PULL, $urandom_range(255), idx == 0);
        if (idx >= strip_bytes.size() && sb.last_status != ST_OK) break;
      end
    end
    send_word(KIND_END, $urandom_range(255), 1'b0);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    word_if.valid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_fill_order(logic rev);
    wait_drained();
    cfg_we_i = 1'b1;
    cfg_wdata_i = rev;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.rev = rev;
  endtask

  task automatic noise_words(int n);
    for (int i = 0; i < n; i++)
      send_word($urandom_range(3), $urandom_range(255), $urandom_range(9) == 0);
  endtask

  initial begin
    sb = new();
    send_idle = 0; recv_stall = 0; hold_req = 0; strips = 0;
    cfg_we_i = 1'b0; cfg_wdata_i = 1'b0;
    word_if.valid = 1'b0; word_if.kind = KIND_FEED;
    word_if.code_byte = 8'h00; word_if.first_of_strip = 1'b0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty decoder, input full, end-check cases, code errors
    send_word(KIND_PULL, 8'h00, 1'b0);
    send_word(KIND_END, 8'h00, 1'b0);
    send_word(KIND_NOP, 8'hFF, 1'b0);
    send_word(KIND_FEED, 8'hFF, 1'b1);
    send_word(KIND_FEED, 8'h00, 1'b0);
    send_word(KIND_FEED, 8'hFF, 1'b0);
    send_word(KIND_FEED, 8'h00, 1'b0);
    send_word(KIND_FEED, 8'hA5, 1'b0);
    send_word(KIND_END, 8'h00, 1'b0);
    code_list = '{END_CODE};
    pack_codes(); drive_strip();
    code_list = '{300, 65, END_CODE};
    pack_codes(); drive_strip();
    code_list = '{CLEAR_CODE, 65, 400, 258, 259, 66, CLEAR_CODE, CLEAR_CODE, 0, 255, END_CODE};
    pack_codes(); drive_strip();

    // Long strip with literal-heavy codes, crossing into 10-bit codes
    make_codes(262, 95, 0);
    pack_codes(); drive_strip();
    write_fill_order(1'b1);

    // Phases of idle/stall mixes, alternating fill order
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1 || ph == 3) ? ((ph == 1) ? 88 : 24) : 0;
      recv_stall = (ph == 2 || ph == 3) ? ((ph == 2) ? 88 : 24) : 0;
      if (ph == 0) hold_req = 1'b1;
      for (int s = 0; s < 2; s++) begin
        make_codes($urandom_range(2, 5), 40, 8);
        pack_codes();
        if ($urandom_range(3) == 0 && strip_bytes.size() > 2)
          strip_bytes[$urandom_range(strip_bytes.size() - 1)] ^= 8'h1 << $urandom_range(7);
        drive_strip();
      end
      noise_words(4);
      write_fill_order(ph[0]);
    end

    wait_drained();
    $display("Covered %0d request words in %0d strips, %0d result words checked.",
             sb.words_in, strips, sb.results);
    $display("Status counts ok/need/early/badclr/badcode/full/left/extra/noend/clean: "
             , "%0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
             sb.status_seen[5], sb.status_seen[6], sb.status_seen[7], sb.status_seen[8],
             sb.status_seen[9], sb.status_seen[10]);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
